// ===== rtl/rgbup_pkg.sv =====
// rgbup_pkg: shared types, constants and pixel helpers for the rgb555 2x upscaler
// depends on nothing; imported by rgbup_emit and rgb555_upscale_2x_interp_core
`timescale 1ns / 1ps

package rgbup_pkg;

  localparam logic [14:0] MASK_GR      = 15'h7fe0;
  localparam logic [14:0] MASK_AVG     = 15'h7bde;
  localparam logic [9:0]  HEIGHT_LIMIT = 10'd512;

  localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FULL_MODE     = 2'd2;

  // result slots in emission order
  localparam int SLOT_COPY  = 0;
  localparam int SLOT_LEFT  = 1;
  localparam int SLOT_ABOVE = 2;
  localparam int SLOT_DIAG  = 3;

  typedef struct packed {
    logic [14:0] cur;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [3:0]  slots;
  } rgbup_item_t;

  function automatic logic [15:0] to565(input logic [14:0] c);
    return 16'(c) + 16'(c & MASK_GR);
  endfunction

  function automatic logic [15:0] blend(input logic [14:0] a, input logic [14:0] b);
    logic [15:0] sum;
    sum = 16'(a & MASK_AVG) + 16'(b & MASK_AVG);
    return to565(sum[15:1]);
  endfunction

endpackage

// ===== rtl/rgbup_emit.sv =====
// rgbup_emit: holds one source pixel and issues its target pixels one per cycle while out_tready allows
// depends on rgbup_pkg; fed by the line memory stage of the core
`timescale 1ns / 1ps

module rgbup_emit
  import rgbup_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_ready,
  input  rgbup_item_t item,
  input  logic [14:0] above,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_pixel, out_col, out_row, zero pad
  output logic        out_tlast   // last_of_item
);

  logic        p_valid_r;
  rgbup_item_t p_r;
  logic [3:0]  pending_r;
  logic [14:0] left_r;
  logic [14:0] upleft_r;

  logic        out_valid_r;
  logic [15:0] opix_r;
  logic [9:0]  ocol_r;
  logic [9:0]  orow_r;
  logic        olast_r;

  logic [3:0]  pick;
  logic [3:0]  remaining;
  logic        last;
  logic        emit;
  logic [15:0] pix;
  logic [9:0]  col;
  logic [9:0]  row;

  always_comb begin
    pick = 4'b0000;
    priority if (pending_r[SLOT_COPY]) begin
      pick[SLOT_COPY] = 1'b1;
    end else if (pending_r[SLOT_LEFT]) begin
      pick[SLOT_LEFT] = 1'b1;
    end else if (pending_r[SLOT_ABOVE]) begin
      pick[SLOT_ABOVE] = 1'b1;
    end else begin
      pick[SLOT_DIAG] = 1'b1;
    end
  end

  always_comb begin
    pix = to565(p_r.cur);
    if (pick[SLOT_LEFT]) begin
      pix = blend(left_r, p_r.cur);
    end else if (pick[SLOT_ABOVE]) begin
      pix = blend(above, p_r.cur);
    end else if (pick[SLOT_DIAG]) begin
      pix = blend(upleft_r, p_r.cur);
    end
    col = (pick[SLOT_LEFT] || pick[SLOT_DIAG]) ? p_r.col - 10'd1 : p_r.col;
    row = (pick[SLOT_ABOVE] || pick[SLOT_DIAG]) ? p_r.row - 10'd1 : p_r.row;
  end

  assign remaining  = pending_r & ~pick;
  assign last       = (remaining == 4'b0000);
  assign emit       = p_valid_r && (!out_valid_r || out_tready);
  assign item_ready = !p_valid_r || (emit && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (item_valid && item_ready) begin
      p_valid_r <= 1'b1;
    end else if (emit && last) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      p_r       <= item;
      pending_r <= item.slots;
    end else if (emit) begin
      pending_r <= remaining;
    end
    // neighbours move on as the held pixel retires
    if (emit && last) begin
      left_r   <= p_r.cur;
      upleft_r <= above;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      opix_r  <= pix;
      ocol_r  <= col;
      orow_r  <= row;
      olast_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, orow_r, ocol_r, opix_r};
  assign out_tlast  = olast_r;

endmodule

// ===== rtl/rgb555_upscale_2x_interp_core.sv =====
// rgb555_upscale_2x_interp_core: top level of the rgb555 to rgb565 2x upscaler
// depends on rgbup_pkg and rgbup_emit; holds counters, registers and line memory
`timescale 1ns / 1ps

// Source pixels arrive in raster order on in_ and each gives one to four
// RGB565 target pixels on out_: its copy at (2x,2y), the left average at
// (2x-1,2y) for x>0 and, with full_mode set, the averages with the pixel above
// and the upper-left pixel on the odd row. One target pixel leaves per cycle
// while out_tready does not stall it, and a source pixel has one to four
// results (four in steady state of full mode); the line memory is read into
// a register as the request is taken, overlapping the previous pixel's output.
// The previous line lives in a MAX_WIDTH deep memory; it is not cleared and
// needs no warm-up. Configuration writes on cfg_ are always taken and should
// be made while the block is idle.

module rgb555_upscale_2x_interp_core
  import rgbup_pkg::*;
#(
  parameter int MAX_WIDTH = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // pixel_in, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_pixel, out_col, out_row, zero pad
  output logic        out_tlast   // last_of_item
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = (XW + 1 > 10) ? XW + 1 : 10;

  logic [9:0]    width_r;
  logic [9:0]    height_r;
  logic          full_r;
  logic [XW-1:0] col_r;
  logic [XW-1:0] col_nxt;
  logic [8:0]    row_r;
  logic [8:0]    row_nxt;

  logic [14:0]   line_mem [MAX_WIDTH];
  logic [14:0]   above_r;

  logic [WW-1:0] w_eff;
  logic [9:0]    h_eff;
  logic [9:0]    r1;
  logic [XW-1:0] x;
  logic [8:0]    y;
  logic [XW:0]   c2;
  logic [9:0]    r2;
  logic [14:0]   cur;
  logic          accept;
  rgbup_item_t   item;

  assign cfg_ready = 1'b1;
  assign cur       = in_tdata[14:0];
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 10'd320;
      height_r <= 10'd180;
      full_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  width_r  <= cfg_data;
        REG_SOURCE_HEIGHT: height_r <= cfg_data;
        REG_FULL_MODE:     full_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = WW'(width_r);
    if (width_r == 10'd0) begin
      w_eff = WW'(1);
    end else if (WW'(width_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
    h_eff = height_r;
    if (height_r == 10'd0) begin
      h_eff = 10'd1;
    end else if (height_r > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end
  end

  // position of this pixel, closing a line left open by a smaller size
  always_comb begin
    x  = col_r;
    r1 = {1'b0, row_r};
    if (WW'(col_r) >= w_eff) begin
      x  = '0;
      r1 = {1'b0, row_r} + 10'd1;
    end
    if (r1 >= h_eff) begin
      r1 = 10'd0;
    end
    y  = r1[8:0];
    c2 = {1'b0, x} + (XW + 1)'(1);
    r2 = r1;
    col_nxt = c2[XW-1:0];
    if (WW'(c2) >= w_eff) begin
      col_nxt = '0;
      r2 = r1 + 10'd1;
      if (r2 >= h_eff) begin
        r2 = 10'd0;
      end
    end
    row_nxt = r2[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // read-first: the old entry comes out as the new pixel goes in
  always_ff @(posedge clk) begin
    if (accept) begin
      above_r     <= line_mem[x];
      line_mem[x] <= cur;
    end
  end

  always_comb begin
    item.cur              = cur;
    item.col              = 10'({x, 1'b0});
    item.row              = {y, 1'b0};
    item.slots[SLOT_COPY]  = 1'b1;
    item.slots[SLOT_LEFT]  = (x != '0);
    item.slots[SLOT_ABOVE] = full_r && (y != 9'd0);
    item.slots[SLOT_DIAG]  = full_r && (y != 9'd0) && (x != '0);
  end

  rgbup_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .above      (above_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for rgb555_upscale_2x_interp_core
// depends on rgbup_pkg and the core rtl; predicts every target pixel and checks it in order
`timescale 1ns / 1ps

module tb;
  import rgbup_pkg::*;

  localparam int LINE_DEPTH = 512;

  typedef struct packed {
    logic [15:0] pixel;
    logic [9:0]  col;
    logic [9:0]  row;
    logic        last;
  } target_px_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SOURCE_WIDTH;
  logic [9:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // pixel_in, zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // out_pixel, out_col, out_row, zero pad
  logic        out_tlast;       // last_of_item

  // scaler state as the block should hold it
  logic [9:0]  cfg_w = 10'd320;
  logic [9:0]  cfg_h = 10'd180;
  logic        cfg_full = 1'b0;
  logic [14:0] line_mem [LINE_DEPTH];
  bit          line_written [LINE_DEPTH];
  logic [14:0] left_px;
  logic [14:0] upleft_px;
  int          col_q = 0;
  int          row_q = 0;

  target_px_t  pending_targets [$];
  int          err_count = 0;
  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int          sink_hold = 0;

  rgb555_upscale_2x_interp_core #(
    .MAX_WIDTH(LINE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] widen565(input logic [14:0] c);
    return {1'b0, c} + {1'b0, c & MASK_GR};
  endfunction

  function automatic logic [15:0] mix565(input logic [14:0] a, input logic [14:0] b);
    logic [15:0] s;
    s = {1'b0, a & MASK_AVG} + {1'b0, b & MASK_AVG};
    return widen565(s[15:1]);
  endfunction

  function automatic int eff_w(input logic [9:0] w);
    if (w == 0) return 1;
    if (w > LINE_DEPTH) return LINE_DEPTH;
    return int'(w);
  endfunction

  function automatic int eff_h(input logic [9:0] h);
    if (h == 0) return 1;
    if (h > HEIGHT_LIMIT) return int'(HEIGHT_LIMIT);
    return int'(h);
  endfunction

  // row the next source pixel lands on under the given sizes
  function automatic int next_row(input logic [9:0] w, input logic [9:0] h);
    int r;
    r = row_q + ((col_q >= eff_w(w)) ? 1 : 0);
    if (r >= eff_h(h)) r = 0;
    return r;
  endfunction

  function automatic bit line_ready(input int w);
    for (int i = 0; i < w; i++) if (!line_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic push_target(input logic [15:0] pix, input int col, input int row,
                             input logic last);
    target_px_t t;
    t.pixel = pix;
    t.col   = 10'(col);
    t.row   = 10'(row);
    t.last  = last;
    pending_targets.push_back(t);
  endtask

  task automatic upscale_pixel(input logic [14:0] pix);
    int x, y;
    logic [14:0] above, diag;
    bit has_left, has_above, has_diag;
    if (col_q >= eff_w(cfg_w)) begin
      col_q = 0;
      row_q++;
    end
    if (row_q >= eff_h(cfg_h)) row_q = 0;
    x = col_q;
    y = row_q;
    above = line_mem[x];
    diag = upleft_px;
    has_left = (x > 0);
    has_above = cfg_full && (y > 0);
    has_diag = has_left && has_above;
    push_target(widen565(pix), 2 * x, 2 * y, !has_left && !has_above);
    if (has_left) push_target(mix565(left_px, pix), 2 * x - 1, 2 * y, !has_above);
    if (has_above) push_target(mix565(above, pix), 2 * x, 2 * y - 1, !has_diag);
    if (has_diag) push_target(mix565(diag, pix), 2 * x - 1, 2 * y - 1, 1'b1);
    upleft_px = above;
    line_mem[x] = pix;
    line_written[x] = 1'b1;
    left_px = pix;
    col_q++;
    if (col_q >= eff_w(cfg_w)) begin
      col_q = 0;
      row_q++;
      if (row_q >= eff_h(cfg_h)) row_q = 0;
    end
  endtask

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 200) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic send_pixel(input logic [14:0] pix);
    int gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, pix};
    // hold the request until it is taken
    do @(posedge clk); while (!in_tready);
    upscale_pixel(pix);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_targets.size() > 0) @(posedge clk);
  endtask

  task automatic cfg_send(input logic [1:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOURCE_WIDTH:  cfg_w = val;
      REG_SOURCE_HEIGHT: cfg_h = val;
      REG_FULL_MODE:     cfg_full = val[0];
      default: ;
    endcase
  endtask

  // called with the block idle; never lets an unwritten line entry be read
  task automatic set_config(input logic [9:0] w, input logic [9:0] h, input logic m);
    if (next_row(w, h) != 0 && !line_ready(eff_w(w))) begin
      while (next_row(cfg_w, cfg_h) != 0) send_pixel(15'($urandom));
      drain();
    end
    cfg_send(REG_SOURCE_WIDTH, w);
    cfg_send(REG_SOURCE_HEIGHT, h);
    cfg_send(REG_FULL_MODE, {9'd0, m});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_values();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    send_pixel(15'h0000);
    send_pixel(15'h7fff);
    send_pixel(15'h7c00);
    send_pixel(15'h03e0);
    send_pixel(15'h001f);
    drain();
  endtask

  // shrinking the width mid-line closes it, then full mode on a tiny frame
  task automatic test_small_full();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    set_config(10'd3, 10'd2, 1'b1);
    send_pixel(15'h001f);
    send_pixel(15'h7fff);
    send_pixel(15'h0000);
    send_pixel(15'h5555);
    send_pixel(15'h2aaa);
    send_pixel(15'h7c00);
    send_pixel(15'h03e0);
    drain();
  endtask

  task automatic test_zero_sizes();
    src_idle = 1'b0;
    sink_idle = 1'b1;
    set_config(10'd0, 10'd0, 1'b1);
    send_pixel(15'h7fff);
    send_pixel(15'h0000);
    send_pixel(15'h4210);
    drain();
  endtask

  task automatic test_height_shrink();
    src_idle = 1'b1;
    sink_idle = 1'b0;
    set_config(10'd4, 10'd3, 1'b1);
    repeat (6) send_pixel(15'($urandom));
    drain();
    set_config(10'd4, 10'd1, 1'b1);
    repeat (3) send_pixel(15'($urandom));
    drain();
  endtask

  task automatic test_max_width();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    set_config(10'd1023, 10'd1023, 1'b1);
    repeat (66) send_pixel(15'($urandom));
    drain();
  endtask

  task automatic test_max_height();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    set_config(10'd1, 10'd1023, 1'b1);
    repeat (40) send_pixel(15'($urandom));
    drain();
  endtask

  task automatic test_backpressure();
    src_idle = 1'b0;
    sink_idle = 1'b1;
    set_config(10'd8, 10'd4, 1'b1);
    sink_hold = 300;
    repeat (40) send_pixel(15'($urandom));
    drain();
  endtask

  task automatic test_random();
    int left, len;
    logic [9:0] w, h;
    logic m;
    left = 250;
    while (left > 0) begin
      len = $urandom_range(15, 50);
      if (len > left) len = left;
      case ($urandom_range(0, 9))
        0:       w = 10'd0;
        1:       w = 10'($urandom_range(17, 64));
        default: w = 10'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 9))
        0:       h = 10'd0;
        1:       h = 10'($urandom_range(9, 1023));
        default: h = 10'($urandom_range(1, 8));
      endcase
      m = ($urandom_range(0, 3) != 0);
      set_config(w, h, m);
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      repeat (len) send_pixel(15'($urandom));
      drain();
      left -= len;
    end
  endtask

  // result receiver
  initial begin : sink
    int gap;
    wait (rst_n);
    forever begin
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      gap = sink_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin : check_targets
    target_px_t want;
    logic [15:0] got_pixel;
    logic [9:0]  got_col, got_row;
    if (rst_n && out_tvalid && out_tready) begin
      got_pixel = out_tdata[15:0];
      got_col   = out_tdata[25:16];
      got_row   = out_tdata[35:26];
      if (pending_targets.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h col %0d row %0d",
                                  got_pixel, got_col, got_row));
      end else begin
        want = pending_targets.pop_front();
        if (got_pixel !== want.pixel || got_col !== want.col ||
            got_row !== want.row || out_tlast !== want.last) begin
          report_mismatch($sformatf(
            "got px %h col %0d row %0d last %b, want px %h col %0d row %0d last %b",
            got_pixel, got_col, got_row, out_tlast,
            want.pixel, want.col, want.row, want.last));
        end
      end
    end
  end

  initial begin : run_limit
    #(2_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_small_full();
    test_zero_sizes();
    test_height_shrink();
    test_max_width();
    test_max_height();
    test_backpressure();
    test_random();
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_targets.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_targets.size() > 0)
      report_mismatch($sformatf("%0d target pixels never arrived", pending_targets.size()));
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rgbup_pkg.sv
rtl/rgbup_emit.sv
rtl/rgb555_upscale_2x_interp_core.sv
tb/sv/tb.sv
